>>> src/video_tile_layout_assert.svh
// ----------------------------------------------------------------------------
// video_tile_layout_assert
// Assertion macros used by the tile layout RTL.
// ----------------------------------------------------------------------------
`ifndef VIDEO_TILE_LAYOUT_ASSERT_SVH
`define VIDEO_TILE_LAYOUT_ASSERT_SVH

// same-cycle implication
`define VTL_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tile layout assertion failed");

// next-cycle implication
`define VTL_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tile layout assertion failed");

`endif

>>> src/vtl_pkg.sv
// ----------------------------------------------------------------------------
// vtl_pkg
// Widths, register indexes, layout codes and constants of the tile layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vtl_pkg;

  localparam int DIM_W      = 13;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int POS_W      = 15;
  localparam int SIZE_W     = 14;
  localparam int MODE_W     = 2;
  localparam int PAD_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int FIT_NW     = 2 * DIM_W + 1;
  localparam int FIT_DW     = DIM_W + 1;

  localparam int SQRT_LIMIT       = 16;
  localparam int PREVIEW_MIN_ZOOM = 6;
  localparam int LONE_SHRINK      = 16;
  localparam int LONE_SHIFT       = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER     = 3'd4;

  localparam logic [MODE_W-1:0] MODE_GRID    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREVIEW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SINGLE  = 2'd2;

endpackage

`default_nettype wire

>>> src/vtl_if.sv
// ----------------------------------------------------------------------------
// vtl_if
// Valid/ready channels carrying tile requests and tile placements.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vtl_in_if import vtl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] tile_index;
  logic [CNT_W-1:0] source_count;
  logic [DIM_W-1:0] src_width;
  logic [DIM_W-1:0] src_height;
  logic             rotated;

  modport source (output valid, tile_index, source_count, src_width, src_height, rotated,
                  input ready);
  modport sink (input valid, tile_index, source_count, src_width, src_height, rotated,
                output ready);
endinterface

interface vtl_out_if import vtl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     valid_res;
  logic signed [POS_W-1:0]  tile_x;
  logic signed [POS_W-1:0]  tile_y;
  logic signed [SIZE_W-1:0] tile_w;
  logic signed [SIZE_W-1:0] tile_h;

  modport source (output valid, valid_res, tile_x, tile_y, tile_w, tile_h, input ready);
  modport sink (input valid, valid_res, tile_x, tile_y, tile_w, tile_h, output ready);
endinterface

`default_nettype wire

>>> src/vtl_div.sv
// ----------------------------------------------------------------------------
// vtl_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor, with a tag carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vtl_div #(
  parameter int LANES = 1,
  parameter int NW    = 8,
  parameter int DW    = 8,
  parameter int TW    = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       vld_in,
  input  wire logic [LANES-1:0][NW-1:0]   num_in,
  input  wire logic [DW-1:0]              den_in,
  input  wire logic [TW-1:0]              tag_in,
  output logic                            vld_out,
  output logic [LANES-1:0][NW-1:0]        quo_out,
  output logic [LANES-1:0][DW-1:0]        rem_out,
  output logic [TW-1:0]                   tag_out
);

  logic                     vld_r [NW];
  logic [LANES-1:0][NW-1:0] qn_r  [NW];
  logic [LANES-1:0][DW-1:0] rem_r [NW];
  logic [DW-1:0]            den_r [NW];
  logic [TW-1:0]            tag_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic                     vld_i;
    logic [LANES-1:0][NW-1:0] qn_i;
    logic [LANES-1:0][DW-1:0] rem_i;
    logic [DW-1:0]            den_i;
    logic [TW-1:0]            tag_i;
    logic [LANES-1:0][NW-1:0] qn_nxt;
    logic [LANES-1:0][DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign vld_i = vld_in;
      assign qn_i  = num_in;
      assign rem_i = '0;
      assign den_i = den_in;
      assign tag_i = tag_in;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign qn_i  = qn_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign tag_i = tag_r[k-1];
    end

    always_comb begin : p_step
      logic [DW:0] trial;
      logic        qbit;
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_i[l], qn_i[l][NW-1]};
        if (trial >= {1'b0, den_i}) begin
          trial = trial - {1'b0, den_i};
          qbit  = 1'b1;
        end else begin
          qbit  = 1'b0;
        end
        rem_nxt[l] = trial[DW-1:0];
        qn_nxt[l]  = {qn_i[l][NW-2:0], qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qn_r[k]  <= qn_nxt;
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_i;
        tag_r[k] <= tag_i;
      end
    end
  end

  assign vld_out = vld_r[NW-1];
  assign quo_out = qn_r[NW-1];
  assign rem_out = rem_r[NW-1];
  assign tag_out = tag_r[NW-1];

endmodule

`default_nettype wire

>>> src/video_tile_layout.sv
// ----------------------------------------------------------------------------
// video_tile_layout
// Places one tile of a multi-source video composite: grid, big tile with
// preview row, or single tile, with aspect fit, padding and border.
// ----------------------------------------------------------------------------
// Fully pipelined: one tile request per cycle while the output is not stalled,
// with the placement registered through the input register, 13-stage cell
// divider, two cell and product stages, 27-stage fit divider and output
// register. The whole pipeline stalls together while a finished placement
// waits at the output; most of the stages lie in the two dividers. A disabled
// composite or an empty cell returns valid_res low with all fields zero.
`timescale 1ns / 1ps
`default_nettype none

`include "video_tile_layout_assert.svh"

module video_tile_layout import vtl_pkg::*; #(
  parameter int MAX_SOURCES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  vtl_in_if.sink                     in_bus,
  vtl_out_if.source                  out_bus,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ZMAX = (MAX_SOURCES > PREVIEW_MIN_ZOOM) ? MAX_SOURCES : PREVIEW_MIN_ZOOM;
  localparam int ZW   = $clog2(ZMAX + 1);
  localparam int NBW  = $clog2(MAX_SOURCES + 1);
  localparam int MW   = (ZW > IDX_W) ? ZW : IDX_W;
  localparam int PW   = MW + DIM_W + 2;
  localparam int L1   = 5;
  localparam int LN_W = 0;
  localparam int LN_H = 1;
  localparam int LN_I = 2;
  localparam int LN_N = 3;
  localparam int LN_M = 4;

  localparam logic signed [PW-1:0] X_LO = PW'(-16384);
  localparam logic signed [PW-1:0] X_HI = PW'(16383);
  localparam logic signed [PW-1:0] S_LO = PW'(-1024);
  localparam logic signed [PW-1:0] S_HI = PW'(8191);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [ZW-1:0]    zoom;
    logic [NBW-1:0]   n;
    logic             previews;
    logic             grid;
    logic             lone;
    logic             ok;
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
  } t1_t;

  typedef struct packed {
    logic                    ok;
    logic                    big0;
    logic                    previews;
    logic                    grid;
    logic                    lone;
    logic [IDX_W-1:0]        idx;
    logic [ZW-1:0]           zoom;
    logic [DIM_W-1:0]        sw;
    logic [DIM_W-1:0]        sh;
    logic signed [POS_W-1:0] cw;
    logic signed [POS_W-1:0] ch;
    logic [IDX_W-1:0]        iq;
    logic [ZW-1:0]           ir;
    logic [ZW-1:0]           nr;
    logic [NBW-1:0]          n1q;
    logic [NBW-1:0]          n;
    logic [DIM_W-1:0]        hq;
  } b1_t;

  typedef struct packed {
    logic                     ok;
    logic                     big0;
    logic                     previews;
    logic                     grid;
    logic                     lone;
    logic                     nr_nz;
    logic [IDX_W-1:0]         idx;
    logic [DIM_W-1:0]         sw;
    logic [DIM_W-1:0]         sh;
    logic signed [POS_W-1:0]  cw;
    logic signed [POS_W-1:0]  ch;
    logic [DIM_W-1:0]         hq;
    logic [MW+DIM_W-1:0]      pa;
    logic [MW+DIM_W-1:0]      pb;
    logic [IDX_W+DIM_W-1:0]   pc;
    logic [ZW+NBW-1:0]        pd;
    logic [2*DIM_W-1:0]       pe;
    logic [2*DIM_W-1:0]       pf;
  } b2_t;

  typedef struct packed {
    logic                    ok;
    logic                    sel;
    logic                    zero;
    logic signed [PW-1:0]    cx;
    logic signed [PW-1:0]    cy;
    logic signed [POS_W-1:0] cw;
    logic signed [POS_W-1:0] ch;
  } t3_t;

  function automatic logic signed [PW-1:0] half_t(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] adj;
    adj    = $signed({{(PW-1){1'b0}}, v[PW-1]});
    half_t = (v + adj) >>> 1;
  endfunction

  // configuration
  logic [DIM_W-1:0]  w_r, h_r;
  logic [MODE_W-1:0] mode_r;
  logic [PAD_W-1:0]  pad_r, bor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= '0;
      h_r    <= '0;
      mode_r <= MODE_GRID;
      pad_r  <= '0;
      bor_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OUT_WIDTH:  w_r    <= cfg_data[DIM_W-1:0];
        CFG_OUT_HEIGHT: h_r    <= cfg_data[DIM_W-1:0];
        CFG_MODE:       mode_r <= cfg_data[MODE_W-1:0];
        CFG_PADDING:    pad_r  <= cfg_data[PAD_W-1:0];
        CFG_BORDER:     bor_r  <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic out_vld_r;
  logic en;
  assign en           = !out_vld_r || out_bus.ready;
  assign in_bus.ready = en;

  // stage 0: input register
  logic             s0_vld_r;
  logic [IDX_W-1:0] s0_idx_r;
  logic [CNT_W-1:0] s0_cnt_r;
  logic [DIM_W-1:0] s0_sw_r, s0_sh_r;
  logic             s0_rot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_idx_r <= in_bus.tile_index;
      s0_cnt_r <= in_bus.source_count;
      s0_sw_r  <= in_bus.src_width;
      s0_sh_r  <= in_bus.src_height;
      s0_rot_r <= in_bus.rotated;
    end
  end

  // count and zoom
  logic [NBW-1:0]           n_a;
  logic [ZW-1:0]            zoom_a;
  int                       sq_cnt;
  t1_t                      t1_a;
  logic [L1-1:0][DIM_W-1:0] d1_num;

  always_comb begin
    if (mode_r == MODE_SINGLE) begin
      n_a = NBW'(1);
    end else if (int'(s0_cnt_r) > MAX_SOURCES) begin
      n_a = NBW'(MAX_SOURCES);
    end else begin
      n_a = NBW'(s0_cnt_r);
    end
    sq_cnt = 0;
    for (int z = 0; z <= SQRT_LIMIT; z++) begin
      if (z * z < int'(n_a)) sq_cnt++;
    end
    if (mode_r == MODE_PREVIEW) begin
      zoom_a = (int'(n_a) > PREVIEW_MIN_ZOOM) ? ZW'(n_a) : ZW'(PREVIEW_MIN_ZOOM);
    end else begin
      zoom_a = ZW'(sq_cnt);
    end
    t1_a.idx      = s0_idx_r;
    t1_a.zoom     = zoom_a;
    t1_a.n        = n_a;
    t1_a.previews = (mode_r == MODE_PREVIEW);
    t1_a.grid     = (mode_r == MODE_GRID);
    t1_a.lone     = (n_a == NBW'(1));
    t1_a.ok       = (w_r != '0) && (h_r != '0) && (n_a != '0);
    t1_a.sw       = s0_rot_r ? s0_sh_r : s0_sw_r;
    t1_a.sh       = s0_rot_r ? s0_sw_r : s0_sh_r;
    d1_num[LN_W]  = w_r;
    d1_num[LN_H]  = h_r;
    d1_num[LN_I]  = DIM_W'(s0_idx_r);
    d1_num[LN_N]  = DIM_W'(n_a);
    d1_num[LN_M]  = DIM_W'(n_a) - DIM_W'(1);
  end

  // cell divider: everything over zoom
  logic                     d1_vld;
  logic [L1-1:0][DIM_W-1:0] d1_q;
  logic [L1-1:0][ZW-1:0]    d1_rm;
  t1_t                      d1_tag;

  vtl_div #(.LANES(L1), .NW(DIM_W), .DW(ZW), .TW($bits(t1_t))) u_cell_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (s0_vld_r),
    .num_in  (d1_num),
    .den_in  (zoom_a),
    .tag_in  (t1_a),
    .vld_out (d1_vld),
    .quo_out (d1_q),
    .rem_out (d1_rm),
    .tag_out (d1_tag)
  );

  // stage B1: cell size
  b1_t b1_nxt, b1_r;
  logic b1_vld_r;

  always_comb begin
    b1_nxt.big0     = d1_tag.previews && (d1_tag.idx == '0);
    b1_nxt.previews = d1_tag.previews;
    b1_nxt.grid     = d1_tag.grid;
    b1_nxt.lone     = d1_tag.lone;
    b1_nxt.idx      = d1_tag.idx;
    b1_nxt.zoom     = d1_tag.zoom;
    b1_nxt.sw       = d1_tag.sw;
    b1_nxt.sh       = d1_tag.sh;
    if (b1_nxt.big0) begin
      b1_nxt.cw = $signed(POS_W'(w_r));
      b1_nxt.ch = $signed(POS_W'(h_r)) - $signed(POS_W'(d1_q[LN_H]));
    end else begin
      b1_nxt.cw = $signed(POS_W'(d1_q[LN_W]));
      b1_nxt.ch = $signed(POS_W'(d1_q[LN_H]));
      if (d1_tag.lone) begin
        b1_nxt.cw = b1_nxt.cw - POS_W'(LONE_SHRINK);
        b1_nxt.ch = b1_nxt.ch - POS_W'(LONE_SHRINK);
      end
    end
    b1_nxt.ok  = d1_tag.ok && (b1_nxt.cw > 0) && (b1_nxt.ch > 0);
    b1_nxt.iq  = d1_q[LN_I][IDX_W-1:0];
    b1_nxt.ir  = d1_rm[LN_I];
    b1_nxt.nr  = d1_rm[LN_N];
    b1_nxt.n1q = d1_q[LN_M][NBW-1:0];
    b1_nxt.n   = d1_tag.n;
    b1_nxt.hq  = d1_q[LN_H];
  end

  // stage B2: products
  b2_t b2_nxt, b2_r;
  logic b2_vld_r;
  logic [MW-1:0]    ma, mb;
  logic [DIM_W-1:0] cwu, chu;

  always_comb begin
    cwu = b1_r.cw[DIM_W-1:0];
    chu = b1_r.ch[DIM_W-1:0];
    ma  = b1_r.previews ? MW'(b1_r.idx) - MW'(1) : MW'(b1_r.ir);
    mb  = b1_r.previews ? MW'(b1_r.n) - MW'(1) : MW'(b1_r.nr);
    b2_nxt.ok       = b1_r.ok;
    b2_nxt.big0     = b1_r.big0;
    b2_nxt.previews = b1_r.previews;
    b2_nxt.grid     = b1_r.grid;
    b2_nxt.lone     = b1_r.lone;
    b2_nxt.nr_nz    = (b1_r.nr != '0);
    b2_nxt.idx      = b1_r.idx;
    b2_nxt.sw       = b1_r.sw;
    b2_nxt.sh       = b1_r.sh;
    b2_nxt.cw       = b1_r.cw;
    b2_nxt.ch       = b1_r.ch;
    b2_nxt.hq       = b1_r.hq;
    b2_nxt.pa       = (MW+DIM_W)'(ma) * (MW+DIM_W)'(cwu);
    b2_nxt.pb       = (MW+DIM_W)'(mb) * (MW+DIM_W)'(cwu);
    b2_nxt.pc       = (IDX_W+DIM_W)'(b1_r.iq) * (IDX_W+DIM_W)'(chu);
    b2_nxt.pd       = (ZW+NBW)'(b1_r.zoom) * (ZW+NBW)'(b1_r.n1q);
    b2_nxt.pe       = (2*DIM_W)'(b1_r.sw) * (2*DIM_W)'(chu);
    b2_nxt.pf       = (2*DIM_W)'(b1_r.sh) * (2*DIM_W)'(cwu);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
    end else if (en) begin
      b1_vld_r <= d1_vld;
      b2_vld_r <= b1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r <= b1_nxt;
      b2_r <= b2_nxt;
    end
  end

  // stage B3: cell position and fit operands
  t3_t                 t3_a;
  logic signed [PW-1:0] cen;
  logic [FIT_NW-1:0]   fit_num;
  logic [FIT_DW-1:0]   fit_den;
  logic [0:0][FIT_NW-1:0] d2_num;

  always_comb begin
    cen = half_t($signed(PW'(w_r)) - $signed(PW'(b2_r.pb)));
    if (b2_r.previews) begin
      if (b2_r.big0) begin
        t3_a.cx = '0;
        t3_a.cy = $signed(PW'(b2_r.hq));
      end else begin
        t3_a.cx = $signed(PW'(b2_r.pa)) + cen;
        t3_a.cy = '0;
      end
    end else begin
      t3_a.cx = $signed(PW'(b2_r.pa));
      if (b2_r.grid && b2_r.nr_nz && (32'(b2_r.idx) >= 32'(b2_r.pd))) begin
        t3_a.cx = t3_a.cx + cen;
      end
      t3_a.cy = $signed(PW'(b2_r.pc));
      if (b2_r.lone) begin
        t3_a.cx = t3_a.cx + PW'(LONE_SHIFT);
        t3_a.cy = t3_a.cy + PW'(LONE_SHIFT);
      end
    end
    t3_a.ok   = b2_r.ok;
    t3_a.sel  = (b2_r.pe >= b2_r.pf);
    t3_a.zero = (b2_r.sw == '0) && (b2_r.sh == '0);
    t3_a.cw   = b2_r.cw;
    t3_a.ch   = b2_r.ch;
    if (t3_a.sel) begin
      fit_num = {b2_r.pf, 1'b0} + FIT_NW'(b2_r.sw);
      fit_den = {b2_r.sw, 1'b0};
    end else begin
      fit_num = {b2_r.pe, 1'b0} + FIT_NW'(b2_r.sh);
      fit_den = {b2_r.sh, 1'b0};
    end
    d2_num[0] = fit_num;
  end

  // fit divider
  logic                   d2_vld;
  logic [0:0][FIT_NW-1:0] d2_q;
  logic [0:0][FIT_DW-1:0] d2_rm;
  t3_t                    d2_tag;

  vtl_div #(.LANES(1), .NW(FIT_NW), .DW(FIT_DW), .TW($bits(t3_t))) u_fit_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (b2_vld_r),
    .num_in  (d2_num),
    .den_in  (fit_den),
    .tag_in  (t3_a),
    .vld_out (d2_vld),
    .quo_out (d2_q),
    .rem_out (d2_rm),
    .tag_out (d2_tag)
  );

  // stage B4: final placement
  logic signed [POS_W-1:0] qs, fw, fh;
  logic signed [PW-1:0]    fx, fy, xs, ys, ws, hs, inset;
  logic                    res_nxt;
  logic signed [POS_W-1:0] x_nxt, y_nxt;
  logic signed [SIZE_W-1:0] w_nxt, h_nxt;

  always_comb begin
    qs    = $signed({1'b0, d2_q[0][FIT_DW-1:0]});
    fw    = (d2_tag.zero || d2_tag.sel) ? d2_tag.cw : qs;
    fh    = (d2_tag.zero || !d2_tag.sel) ? d2_tag.ch : qs;
    fx    = d2_tag.cx + half_t(PW'(d2_tag.cw) - PW'(fw));
    fy    = d2_tag.cy + half_t(PW'(d2_tag.ch) - PW'(fh));
    inset = $signed(PW'({1'b0, pad_r} + {1'b0, bor_r}));
    xs    = fx + inset;
    ys    = fy + inset;
    ws    = PW'(fw) - (inset <<< 1);
    hs    = PW'(fh) - (inset <<< 1);
    if (xs < X_LO) xs = X_LO;
    if (xs > X_HI) xs = X_HI;
    if (ys < X_LO) ys = X_LO;
    if (ys > X_HI) ys = X_HI;
    if (ws < S_LO) ws = S_LO;
    if (ws > S_HI) ws = S_HI;
    if (hs < S_LO) hs = S_LO;
    if (hs > S_HI) hs = S_HI;
    res_nxt = d2_tag.ok;
    if (d2_tag.ok) begin
      x_nxt = xs[POS_W-1:0];
      y_nxt = ys[POS_W-1:0];
      w_nxt = ws[SIZE_W-1:0];
      h_nxt = hs[SIZE_W-1:0];
    end else begin
      x_nxt = '0;
      y_nxt = '0;
      w_nxt = '0;
      h_nxt = '0;
    end
  end

  logic                     out_res_r;
  logic signed [POS_W-1:0]  out_x_r, out_y_r;
  logic signed [SIZE_W-1:0] out_w_r, out_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= res_nxt;
      out_x_r   <= x_nxt;
      out_y_r   <= y_nxt;
      out_w_r   <= w_nxt;
      out_h_r   <= h_nxt;
    end
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.valid_res = out_res_r;
  assign out_bus.tile_x    = out_x_r;
  assign out_bus.tile_y    = out_y_r;
  assign out_bus.tile_w    = out_w_r;
  assign out_bus.tile_h    = out_h_r;

  `VTL_ASSERT_NXT(a_out_hold, clk, rst_n, out_vld_r && !out_bus.ready,
                  out_vld_r && $stable(out_x_r) && $stable(out_w_r) && $stable(out_res_r))
  `VTL_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_vld_r && !out_res_r,
                  out_x_r == '0 && out_y_r == '0 && out_w_r == '0 && out_h_r == '0)
  `VTL_ASSERT_NXT(a_pipe_freeze, clk, rst_n, !en,
                  $stable(s0_vld_r) && $stable(b1_vld_r) && $stable(b2_vld_r))

endmodule

`default_nettype wire
